// ===== hdl/prt_pkg.sv =====
// Shared types and constants for the pending request table.
// Holds the request and result structs, the controller command and status
// structs, and the status and kind codes. Depends on nothing.
package prt_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_ID_WIDTH    = 16;

  localparam int FIELD_W  = 16;
  localparam int SLOT_W   = 10;
  localparam int STATUS_W = 2;

  // The busy bits are kept in rows of this many bits.
  localparam int ROW_W  = 32;
  localparam int ROW_BW = 5;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [FIELD_W-1:0] requester_id;
    logic [FIELD_W-1:0] requester_port;
    logic [FIELD_W-1:0] target_id;
    logic [SLOT_W-1:0]  slot_in;
  } prt_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;
    logic [FIELD_W-1:0]  found_requester;
    logic [FIELD_W-1:0]  found_port;
  } prt_res_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic issue;
    logic ins_done;
    logic rem_done;
  } prt_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic found;
    logic scan_end;
  } prt_sts_t;

endpackage

// ===== hdl/prt_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the busy-bit rows and the stored request entries. No dependencies.
module prt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/prt_ctrl.sv =====
// Controller state machine of the pending request table.
// Sequences the clearing pass, the free-slot scan and the remove lookup.
// Depends on prt_pkg.
module prt_ctrl import prt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     kind,
  input  prt_sts_t sts,
  output prt_cmd_t cmd,
  output logic     busy
);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_REM_RD  = 3'd3;
  localparam logic [2:0] S_REM_CHK = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (kind == KIND_INSERT) ? S_SCAN : S_REM_RD;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.found || sts.scan_end) begin
          cmd.ins_done = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_REM_RD: begin
        cmd.issue = 1'b1;
        state_nxt = S_REM_CHK;
      end
      S_REM_CHK: begin
        cmd.rem_done = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== hdl/prt_dp.sv =====
// Datapath of the pending request table: busy-bit rows, entry store,
// scan pointer, row search and result register.
// Depends on prt_pkg and prt_ram.
module prt_dp import prt_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int ID_WIDTH    = DEF_ID_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  prt_req_t in_data,
  input  prt_cmd_t cmd,
  output prt_sts_t sts,
  output logic     out_valid,
  output prt_res_t out_data
);

  localparam int SIW   = $clog2(TABLE_DEPTH);
  localparam int ROWS  = (TABLE_DEPTH + ROW_W - 1) / ROW_W;
  localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SXW   = RAW + ROW_BW;
  localparam int CNT_W = $clog2(ROWS + 2);
  localparam int DW    = 2 * ID_WIDTH + FIELD_W;

  logic [SXW-1:0]      ptr_r;
  logic [RAW-1:0]      row_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [RAW-1:0]      chk_row_r;
  logic [CNT_W-1:0]    chk_cnt_r;
  logic                chk_vld_r;
  logic [ID_WIDTH-1:0] id_r;
  logic [FIELD_W-1:0]  port_r;
  logic [ID_WIDTH-1:0] tgt_r;
  logic [SXW-1:0]      slot_r;
  logic                in_range_r;
  logic                out_valid_r;
  prt_res_t            out_r;
  prt_res_t            out_nxt;

  logic [RAW-1:0]      row_inc;
  logic [31:0]         slot_w;
  logic [31:0]         id_w;
  logic [31:0]         tgt_w;
  logic [ROW_W-1:0]    busy_q;
  logic [DW-1:0]       ent_q;
  logic [ID_WIDTH-1:0] ent_req;
  logic [FIELD_W-1:0]  ent_port;
  logic [ID_WIDTH-1:0] ent_tgt;
  logic [31:0]         ent_req_w;
  logic [ROW_BW-1:0]   sb;
  logic [ROW_W-1:0]    free_vec;
  logic [ROW_BW-1:0]   found_bit;
  logic [SXW-1:0]      found_slot;
  logic [31:0]         found_slot_w;
  logic                found;
  logic                scan_end;
  logic [ROW_BW-1:0]   rbit;
  logic                match;
  logic                busy_we;
  logic [RAW-1:0]      busy_waddr;
  logic [ROW_W-1:0]    busy_wdata;
  logic                ent_we;

  assign row_inc = (row_r == RAW'(ROWS - 1)) ? '0 : row_r + 1'b1;
  assign slot_w  = 32'(in_data.slot_in);
  assign id_w    = 32'(in_data.requester_id);
  assign tgt_w   = 32'(in_data.target_id);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      row_r       <= '0;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      chk_vld_r   <= cmd.issue;
      out_valid_r <= cmd.ins_done | cmd.rem_done;
      if (cmd.load) begin
        cnt_r <= '0;
        if (in_data.kind == KIND_INSERT) begin
          row_r <= ptr_r[SXW-1:ROW_BW];
        end else begin
          row_r <= slot_w[SXW-1:ROW_BW];
        end
      end else if (cmd.issue) begin
        row_r <= row_inc;
        cnt_r <= cnt_r + 1'b1;
      end else if (cmd.clr_step) begin
        row_r <= row_inc;
      end
      if (cmd.ins_done && found) begin
        ptr_r <= (found_slot == SXW'(TABLE_DEPTH - 1)) ? '0 : found_slot + 1'b1;
      end
    end
  end

  always_comb begin
    out_nxt = '0;
    if (cmd.ins_done) begin
      out_nxt.status = found ? ST_OK : ST_FULL;
      if (found) begin
        out_nxt.slot_out = found_slot_w[SLOT_W-1:0];
      end
    end else if (match) begin
      out_nxt.status          = ST_OK;
      out_nxt.found_requester = ent_req_w[FIELD_W-1:0];
      out_nxt.found_port      = ent_port;
    end else begin
      out_nxt.status = ST_NOMATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      chk_row_r <= row_r;
      chk_cnt_r <= cnt_r;
    end
    if (cmd.load) begin
      id_r       <= id_w[ID_WIDTH-1:0];
      port_r     <= in_data.requester_port;
      tgt_r      <= tgt_w[ID_WIDTH-1:0];
      slot_r     <= slot_w[SXW-1:0];
      in_range_r <= (slot_w < 32'(TABLE_DEPTH));
    end
    if (cmd.ins_done || cmd.rem_done) begin
      out_r <= out_nxt;
    end
  end

  // Free-slot search within the row under check. The first visit looks at
  // the pointer's bit and above; the final visit, back in the same row,
  // looks below it.
  assign sb = ptr_r[ROW_BW-1:0];

  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      logic in_win;
      logic exists;
      exists = (32'({chk_row_r, ROW_BW'(j)}) < 32'(TABLE_DEPTH));
      if (chk_cnt_r == '0) begin
        in_win = (ROW_BW'(j) >= sb);
      end else if (chk_cnt_r == CNT_W'(ROWS)) begin
        in_win = (ROW_BW'(j) < sb);
      end else begin
        in_win = 1'b1;
      end
      free_vec[j] = exists && in_win && !busy_q[j];
    end
  end

  always_comb begin
    found_bit = '0;
    for (int j = ROW_W - 1; j >= 0; j--) begin
      if (free_vec[j]) begin
        found_bit = ROW_BW'(j);
      end
    end
  end

  assign found        = chk_vld_r && (|free_vec);
  assign scan_end     = chk_vld_r && (chk_cnt_r == CNT_W'(ROWS));
  assign found_slot   = {chk_row_r, found_bit};
  assign found_slot_w = 32'(found_slot);

  assign ent_req   = ent_q[DW-1 -: ID_WIDTH];
  assign ent_port  = ent_q[ID_WIDTH +: FIELD_W];
  assign ent_tgt   = ent_q[ID_WIDTH-1:0];
  assign ent_req_w = 32'(ent_req);
  assign rbit      = slot_r[ROW_BW-1:0];
  assign match     = in_range_r && busy_q[rbit] && (ent_tgt == tgt_r);

  always_comb begin
    busy_we    = 1'b0;
    busy_waddr = chk_row_r;
    busy_wdata = busy_q;
    if (cmd.clr_step) begin
      busy_we    = 1'b1;
      busy_waddr = row_r;
      busy_wdata = '0;
    end else if (cmd.ins_done && found) begin
      busy_we    = 1'b1;
      busy_wdata = busy_q | (ROW_W'(1) << found_bit);
    end else if (cmd.rem_done && match) begin
      busy_we    = 1'b1;
      busy_wdata = busy_q & ~(ROW_W'(1) << rbit);
    end
  end

  assign ent_we = cmd.ins_done && found;

  prt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_busy_ram (
    .clk   (clk),
    .we    (busy_we),
    .waddr (busy_waddr),
    .wdata (busy_wdata),
    .raddr (row_r),
    .rdata (busy_q)
  );

  prt_ram #(
    .WIDTH (DW),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (found_slot[SIW-1:0]),
    .wdata ({id_r, port_r, tgt_r}),
    .raddr (slot_r[SIW-1:0]),
    .rdata (ent_q)
  );

  assign sts.clr_last = (row_r == RAW'(ROWS - 1));
  assign sts.found    = found;
  assign sts.scan_end = scan_end;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/pending_request_table.sv =====
// Pending request table: a request is accepted when start is high and busy is
// low, and its single result is shown for exactly one cycle with out_valid,
// in the cycle after the work ends; the receiver cannot stall it. After
// reset the block runs a clearing pass over the busy-bit memory, one row of
// 32 slots per cycle, holding busy high. A remove passes through a read
// state and a check state after acceptance before the next request can be
// accepted. An insert reads the busy-bit rows from the row of the scan
// pointer on until a free slot is found or the table is seen to be full:
// the search reads one row of the busy-bit memory per cycle.
// Depends on prt_pkg, prt_ctrl, prt_dp and prt_ram.
module pending_request_table import prt_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int ID_WIDTH    = DEF_ID_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  prt_req_t in_data,
  output logic     out_valid,
  output prt_res_t out_data
);

  prt_cmd_t cmd;
  prt_sts_t sts;

  prt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_data.kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  prt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/prt_checker.sv =====
// Port-level checks for the pending request table, bound to the top level.
// Depends on prt_pkg and pending_request_table.
module prt_checker import prt_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input prt_res_t out_data
);

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("Result shown without a request in progress.");

  a_accept_makes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("Accepted request did not make the block busy.");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Result strobe lasted more than one cycle.");

  a_failure_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_FULL || out_data.status == ST_NOMATCH))
      |-> (out_data.slot_out == '0 && out_data.found_requester == '0 &&
           out_data.found_port == '0))
    else $error("Failed request returned non-zero fields.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_FULL ||
                   out_data.status == ST_NOMATCH))
    else $error("Result carries an unknown status code.");

endmodule

bind pending_request_table prt_checker u_prt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ===== tb/testbench.sv =====
// Testbench for the pending request table: drives insert and remove requests
// through the start/busy handshake and checks every result against a predictor.
// Depends on prt_pkg and pending_request_table.
`timescale 1ns / 100ps

module testbench;
  import prt_pkg::*;

  localparam int DEPTH       = DEF_TABLE_DEPTH;
  localparam int CYCLE_LIMIT = 400000;

  class request_table_scoreboard;
    bit                 slot_taken[DEPTH];
    bit                 ever_written[DEPTH];
    bit [FIELD_W-1:0]   held_requester[DEPTH];
    bit [FIELD_W-1:0]   held_port[DEPTH];
    bit [FIELD_W-1:0]   held_target[DEPTH];
    bit [SLOT_W-1:0]    scan_ptr;
    int                 taken_count;
    int                 errors;
    prt_res_t           awaited_outcomes[$];

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void log_request(prt_req_t r);
      prt_res_t res;
      int       pos;
      bit       placed;
      res    = '0;
      placed = 0;
      if (r.kind == KIND_INSERT) begin
        pos = int'(scan_ptr);
        for (int n = 0; n < DEPTH && !placed; n++) begin
          if (!slot_taken[pos]) begin
            slot_taken[pos]     = 1'b1;
            ever_written[pos]   = 1'b1;
            held_requester[pos] = r.requester_id;
            held_port[pos]      = r.requester_port;
            held_target[pos]    = r.target_id;
            scan_ptr            = SLOT_W'((pos + 1) % DEPTH);
            res.slot_out        = SLOT_W'(pos);
            taken_count++;
            placed = 1;
          end else begin
            pos = (pos + 1) % DEPTH;
          end
        end
        res.status = placed ? ST_OK : ST_FULL;
      end else if (r.slot_in < DEPTH && slot_taken[r.slot_in] &&
                   held_target[r.slot_in] == r.target_id) begin
        res.status          = ST_OK;
        res.found_requester = held_requester[r.slot_in];
        res.found_port      = held_port[r.slot_in];
        slot_taken[r.slot_in] = 1'b0;
        taken_count--;
      end else begin
        res.status = ST_NOMATCH;
      end
      awaited_outcomes.push_back(res);
    endfunction

    task check_outcome(prt_res_t got);
      prt_res_t want;
      if (awaited_outcomes.size() == 0) begin
        report($sformatf("result with nothing outstanding: 0x%0h", got));
      end else begin
        want = awaited_outcomes.pop_front();
        if (got.status !== want.status)
          report($sformatf("status got %0h expected %0h", got.status, want.status));
        if (got.slot_out !== want.slot_out)
          report($sformatf("slot_out got %0h expected %0h", got.slot_out, want.slot_out));
        if (got.found_requester !== want.found_requester)
          report($sformatf("found_requester got %0h expected %0h",
                           got.found_requester, want.found_requester));
        if (got.found_port !== want.found_port)
          report($sformatf("found_port got %0h expected %0h",
                           got.found_port, want.found_port));
      end
    endtask
  endclass

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  logic     out_valid;
  prt_req_t in_data;
  prt_res_t out_data;

  request_table_scoreboard sb = new();
  int idle_pct    = 0;
  int cycle_count = 0;

  pending_request_table uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && out_valid) begin
      sb.check_outcome(out_data);
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic prt_req_t make_req(logic k, logic [FIELD_W-1:0] rq,
                                        logic [FIELD_W-1:0] pt, logic [FIELD_W-1:0] tg,
                                        logic [SLOT_W-1:0] sl);
    prt_req_t r;
    r.kind           = k;
    r.requester_id   = rq;
    r.requester_port = pt;
    r.target_id      = tg;
    r.slot_in        = sl;
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] rand_field();
    return FIELD_W'($urandom_range(0, 65535));
  endfunction

  function automatic prt_req_t random_insert();
    return make_req(KIND_INSERT, rand_field(), rand_field(), rand_field(),
                    SLOT_W'($urandom_range(0, DEPTH - 1)));
  endfunction

  function automatic prt_req_t matching_remove();
    int s;
    s = $urandom_range(0, DEPTH - 1);
    while (!sb.slot_taken[s]) s = (s + 1) % DEPTH;
    return make_req(KIND_REMOVE, rand_field(), rand_field(), sb.held_target[s],
                    SLOT_W'(s));
  endfunction

  // Only slots that have held a request are named, so no unwritten entry is read.
  function automatic prt_req_t noise_remove();
    int               s;
    logic [FIELD_W-1:0] tg;
    s = $urandom_range(0, DEPTH - 1);
    while (!sb.ever_written[s]) s = (s + 1) % DEPTH;
    case ($urandom_range(0, 2))
      0: tg = rand_field();
      1: tg = sb.held_target[s] ^ (16'h1 << $urandom_range(0, FIELD_W - 1));
      default: tg = sb.held_target[s];
    endcase
    return make_req(KIND_REMOVE, rand_field(), rand_field(), tg, SLOT_W'(s));
  endfunction

  task automatic send_request(prt_req_t r);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (busy !== 1'b0);
    sb.log_request(r);
  endtask

  task automatic random_phase(int n_items, int ins_pct, int noise_pct);
    int roll;
    repeat (n_items) begin
      roll = $urandom_range(0, 99);
      if (sb.taken_count == 0 || roll < ins_pct) begin
        send_request(random_insert());
      end else if (roll < ins_pct + noise_pct) begin
        send_request(noise_remove());
      end else begin
        send_request(matching_remove());
      end
    end
  endtask

  initial begin
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_request(make_req(KIND_INSERT, 16'h0000, 16'h0000, 16'h0000, 10'h000));
    send_request(make_req(KIND_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF));
    send_request(make_req(KIND_INSERT, 16'h1234, 16'hA5A5, 16'h5A5A, 10'h155));
    send_request(make_req(KIND_REMOVE, 16'h0000, 16'h0000, 16'hFFFF, 10'h001));
    send_request(make_req(KIND_REMOVE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h001));
    send_request(make_req(KIND_REMOVE, 16'h0000, 16'h0000, 16'h0001, 10'h000));
    send_request(make_req(KIND_REMOVE, 16'hFFFF, 16'hFFFF, 16'h0000, 10'h000));
    send_request(make_req(KIND_INSERT, 16'h8000, 16'h0001, 16'h8000, 10'h200));
    send_request(make_req(KIND_REMOVE, 16'h0000, 16'h0000, 16'h5A5B, 10'h002));
    send_request(make_req(KIND_REMOVE, 16'h0000, 16'h0000, 16'h5A5A, 10'h002));
    send_request(make_req(KIND_INSERT, 16'h0001, 16'h8000, 16'h7FFF, 10'h000));
    send_request(make_req(KIND_REMOVE, 16'h0000, 16'h0000, 16'h8000, 10'h003));
    send_request(make_req(KIND_REMOVE, 16'h0000, 16'h0000, 16'h7FFF, 10'h004));
    send_request(make_req(KIND_INSERT, 16'hFFFF, 16'h0000, 16'h0000, 10'h3FF));
    send_request(make_req(KIND_REMOVE, 16'h0000, 16'h0000, 16'h0001, 10'h005));
    send_request(make_req(KIND_REMOVE, 16'h0000, 16'h0000, 16'h0000, 10'h005));

    idle_pct = 0;
    random_phase(100, 55, 15);
    idle_pct = 46;
    random_phase(100, 55, 15);
    idle_pct = 0;
    random_phase(100, 55, 15);

    // Fill every slot, let inserts meet a full table, then churn near full.
    idle_pct = 12;
    while (sb.taken_count < DEPTH) send_request(random_insert());
    repeat (3) send_request(random_insert());
    random_phase(150, 50, 20);

    start <= 1'b0;
    while (sb.awaited_outcomes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/prt_pkg.sv
hdl/prt_ram.sv
hdl/prt_ctrl.sv
hdl/prt_dp.sv
hdl/pending_request_table.sv
hdl/prt_checker.sv
tb/testbench.sv
